FILE: rtl/tgpp_pkg.sv
package tgpp_pkg;

  // Common data types.
  typedef logic [7:0]  chan_t;
  typedef logic [15:0] mask_t;

  // Pixel format codes.
  localparam logic [1:0] FMT_32    = 2'd0;
  localparam logic [1:0] FMT_24    = 2'd1;
  localparam logic [1:0] FMT_16    = 2'd2;
  localparam logic [1:0] FMT_UNSUP = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_TINT   = 3'd0;
  localparam logic [2:0] REG_FORMAT = 3'd1;
  localparam logic [2:0] REG_RMASK  = 3'd2;
  localparam logic [2:0] REG_GMASK  = 3'd3;
  localparam logic [2:0] REG_BMASK  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [23:0] TINT_RESET  = 24'hFFFFFF;
  localparam mask_t       RMASK_RESET = 16'hF800;
  localparam mask_t       GMASK_RESET = 16'h07E0;
  localparam mask_t       BMASK_RESET = 16'h001F;

endpackage

FILE: rtl/tgpp_place.sv
module tgpp_place
  import tgpp_pkg::*;
(
  input  chan_t chan,
  input  mask_t mask,
  output mask_t field
);

  logic [3:0] low_pos;
  logic [3:0] high_pos;
  logic [4:0] span;
  logic [3:0] rsh;
  chan_t      reduced;
  mask_t      shifted;

  // Lowest and highest set bits of the mask.
  always_comb begin
    low_pos  = 4'd0;
    high_pos = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask[i]) begin
        low_pos = i[3:0];
      end
    end
    for (int j = 0; j < 16; j++) begin
      if (mask[j]) begin
        high_pos = j[3:0];
      end
    end
  end

  // Run length including gaps; an empty mask has a run of zero, so the
  // channel is shifted out entirely.
  always_comb begin
    if (mask == '0) begin
      span = 5'd0;
    end else begin
      span = {1'b0, high_pos} - {1'b0, low_pos} + 5'd1;
    end
    if (span > 5'd8) begin
      rsh = 4'd0;
    end else begin
      rsh = 4'(5'd8 - span);
    end
  end

  // Drop the low channel bits, move the rest to the field, and clip to the mask.
  always_comb begin
    reduced = chan >> rsh;
    shifted = {8'd0, reduced} << low_pos;
    field   = shifted & mask;
  end

endmodule

FILE: rtl/tinted_gray_pixel_packer.sv
// Three-stage pipeline: input register, scaled channel register, output register.
// An accepted word moves from the input register to the scaled channel register
// and on to the output register. One word is accepted per cycle unless stalled.
// A stalled output fills the stages in turn before the input side stops.
// Synchronous active-high reset empties the pipeline and restores the defaults.
module tinted_gray_pixel_packer
  import tgpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  gray,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] pixel_word,
  output logic        pixel_valid
);

  // Configuration registers.
  logic [23:0] tint_color;
  logic [1:0]  pixel_format;
  mask_t       red_mask;
  mask_t       green_mask;
  mask_t       blue_mask;

  // Pipeline registers.
  logic  s1_valid;
  chan_t s1_gray;
  logic  s2_valid;
  chan_t s2_red;
  chan_t s2_green;
  chan_t s2_blue;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  logic [15:0] prod_red;
  logic [15:0] prod_green;
  logic [15:0] prod_blue;
  logic [15:0] sum_red;
  logic [15:0] sum_green;
  logic [15:0] sum_blue;

  mask_t       field_red;
  mask_t       field_green;
  mask_t       field_blue;
  logic [23:0] pixel_word_next;
  logic        pixel_valid_next;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tint_color   <= TINT_RESET;
      pixel_format <= FMT_32;
      red_mask     <= RMASK_RESET;
      green_mask   <= GMASK_RESET;
      blue_mask    <= BMASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_TINT:   tint_color   <= cfg_data;
        REG_FORMAT: pixel_format <= cfg_data[1:0];
        REG_RMASK:  red_mask     <= cfg_data[15:0];
        REG_GMASK:  green_mask   <= cfg_data[15:0];
        REG_BMASK:  blue_mask    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Each stage advances when it is empty or the next stage takes its word.
  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_gray <= gray;
    end
  end

  // Tint scaling: floor(p / 255) for p up to 255 * 255 equals
  // (p + (p >> 8) + 1) >> 8.
  always_comb begin
    prod_red   = {8'd0, s1_gray} * {8'd0, tint_color[23:16]};
    prod_green = {8'd0, s1_gray} * {8'd0, tint_color[15:8]};
    prod_blue  = {8'd0, s1_gray} * {8'd0, tint_color[7:0]};
    sum_red    = prod_red + {8'd0, prod_red[15:8]} + 16'd1;
    sum_green  = prod_green + {8'd0, prod_green[15:8]} + 16'd1;
    sum_blue   = prod_blue + {8'd0, prod_blue[15:8]} + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_red   <= sum_red[15:8];
      s2_green <= sum_green[15:8];
      s2_blue  <= sum_blue[15:8];
    end
  end

  // Field placement for the masked 16-bit format.
  tgpp_place u_place_red (
    .chan  (s2_red),
    .mask  (red_mask),
    .field (field_red)
  );

  tgpp_place u_place_green (
    .chan  (s2_green),
    .mask  (green_mask),
    .field (field_green)
  );

  tgpp_place u_place_blue (
    .chan  (s2_blue),
    .mask  (blue_mask),
    .field (field_blue)
  );

  // Pack the pixel; overlapping fields add and wrap at 16 bits.
  always_comb begin
    pixel_word_next  = 24'd0;
    pixel_valid_next = 1'b1;
    unique case (pixel_format) inside
      FMT_32, FMT_24: begin
        pixel_word_next = {s2_red, s2_green, s2_blue};
      end
      FMT_16: begin
        pixel_word_next = {8'd0, 16'(field_red + field_green + field_blue)};
      end
      default: begin
        pixel_word_next  = 24'd0;
        pixel_valid_next = 1'b0;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      pixel_word  <= pixel_word_next;
      pixel_valid <= pixel_valid_next;
    end
  end

endmodule
